### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for the concurrent assertions used by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define FCI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define FCI_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/fci_pkg.sv
// ----------------------------------------------------------------------------
// fci_pkg
// Widths, message codes and the breakpoint curve tables of the fader
// curve interpolator.
// ----------------------------------------------------------------------------
package fci_pkg;

   localparam int FRAC_BITS  = 24;
   localparam int GUARD_BITS = 16;
   localparam int NUM_SEGS   = 10;

   localparam int STATUS_W = 8;
   localparam int DATA_W   = 7;
   localparam int CHAN_W   = 4;
   localparam int POS_W    = 2 * DATA_W;
   localparam int SEG_W    = 4;
   localparam int D_W      = 12;                  // widest segment is 2350 steps
   localparam int SLOPE_W  = FRAC_BITS + 6;
   localparam int PROD_W   = D_W + SLOPE_W;
   localparam int LEVEL_W  = FRAC_BITS + 1;
   localparam int FADER_W  = 25;

   localparam logic [STATUS_W-1:0] STATUS_PITCH_BEND = 8'hE0;
   localparam logic [POS_W-1:0]    TOP_POSITION      = 14'd16383;

   localparam logic [LEVEL_W-1:0] ONE_LEVEL = LEVEL_W'(1) << FRAC_BITS;
   localparam logic [FADER_W-1:0] FADER_MAX = FADER_W'(ONE_LEVEL);
   localparam logic [PROD_W:0]    ROUND_HALF = (PROD_W + 1)'(1) << (GUARD_BITS - 1);

   // Elaboration-time math for the tables, all rounded to nearest, ties up.
   localparam logic [127:0] UNIT    = 128'd1000000000;
   localparam int           SHIFT_B = FRAC_BITS + 1;
   localparam int           SHIFT_S = FRAC_BITS + GUARD_BITS + 1;

   localparam logic [POS_W-1:0] CURVE_X [0:NUM_SEGS] = '{
      14'd0, 14'd530, 14'd1700, 14'd2750, 14'd3850, 14'd6100,
      14'd8250, 14'd10600, 14'd12720, 14'd14900, 14'd16383
   };

   localparam logic [LEVEL_W-1:0] BASE_TAB [0:NUM_SEGS-1] = '{
      LEVEL_W'(((128'd0         << SHIFT_B) + UNIT) / (UNIT * 128'd2)),
      LEVEL_W'(((128'd316228    << SHIFT_B) + UNIT) / (UNIT * 128'd2)),
      LEVEL_W'(((128'd1000000   << SHIFT_B) + UNIT) / (UNIT * 128'd2)),
      LEVEL_W'(((128'd3162280   << SHIFT_B) + UNIT) / (UNIT * 128'd2)),
      LEVEL_W'(((128'd10000000  << SHIFT_B) + UNIT) / (UNIT * 128'd2)),
      LEVEL_W'(((128'd31622800  << SHIFT_B) + UNIT) / (UNIT * 128'd2)),
      LEVEL_W'(((128'd100000000 << SHIFT_B) + UNIT) / (UNIT * 128'd2)),
      LEVEL_W'(((128'd177828000 << SHIFT_B) + UNIT) / (UNIT * 128'd2)),
      LEVEL_W'(((128'd316228000 << SHIFT_B) + UNIT) / (UNIT * 128'd2)),
      LEVEL_W'(((128'd562341000 << SHIFT_B) + UNIT) / (UNIT * 128'd2))
   };

   // slope = dY * 2^(F+G) / (1e9 * dX), guard bits below the level LSB
   localparam logic [SLOPE_W-1:0] SLOPE_TAB [0:NUM_SEGS-1] = '{
      SLOPE_W'(((128'd316228    << SHIFT_S) + UNIT * 128'd530)  / (UNIT * 128'd1060)),
      SLOPE_W'(((128'd683772    << SHIFT_S) + UNIT * 128'd1170) / (UNIT * 128'd2340)),
      SLOPE_W'(((128'd2162280   << SHIFT_S) + UNIT * 128'd1050) / (UNIT * 128'd2100)),
      SLOPE_W'(((128'd6837720   << SHIFT_S) + UNIT * 128'd1100) / (UNIT * 128'd2200)),
      SLOPE_W'(((128'd21622800  << SHIFT_S) + UNIT * 128'd2250) / (UNIT * 128'd4500)),
      SLOPE_W'(((128'd68377200  << SHIFT_S) + UNIT * 128'd2150) / (UNIT * 128'd4300)),
      SLOPE_W'(((128'd77828000  << SHIFT_S) + UNIT * 128'd2350) / (UNIT * 128'd4700)),
      SLOPE_W'(((128'd138400000 << SHIFT_S) + UNIT * 128'd2120) / (UNIT * 128'd4240)),
      SLOPE_W'(((128'd246113000 << SHIFT_S) + UNIT * 128'd2180) / (UNIT * 128'd4360)),
      SLOPE_W'(((128'd437659000 << SHIFT_S) + UNIT * 128'd1483) / (UNIT * 128'd2966))
   };

   typedef struct packed {
      logic [POS_W-1:0] pos;
   } fci_pos_type;

   typedef struct packed {
      logic [PROD_W-1:0]  product;
      logic [LEVEL_W-1:0] base;
      logic               top;
   } fci_prod_type;

endpackage

### rtl/core/fci_if.sv
// ----------------------------------------------------------------------------
// fci_if
// Valid/ready channels of the fader curve interpolator: request,
// response and control register write.
// ----------------------------------------------------------------------------
interface fci_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] status_byte;
   logic [6:0] data_low;
   logic [6:0] data_high;

   modport source (output valid, output status_byte, output data_low, output data_high,
                   input ready);
   modport sink   (input valid, input status_byte, input data_low, input data_high,
                   output ready);
endinterface

interface fci_rsp_if;
   logic        valid;
   logic        ready;
   logic [24:0] fader_level;

   modport source (output valid, output fader_level, input ready);
   modport sink   (input valid, input fader_level, output ready);
endinterface

interface fci_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] midi_channel;

   modport source (output valid, output midi_channel, input ready);
   modport sink   (input valid, input midi_channel, output ready);
endinterface

### rtl/core/fci_filter.sv
// ----------------------------------------------------------------------------
// fci_filter
// Input stage: keeps pitch bends on the selected channel and registers
// the joined 14-bit position.
// ----------------------------------------------------------------------------
module fci_filter
   import fci_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [CHAN_W-1:0] midi_channel,
   fci_req_if.sink           req_ch,
   output logic              pos_valid,
   input  logic              pos_ready,
   output fci_pos_type       pos_data
);

   logic        valid_ff, valid_in;
   fci_pos_type data_ff, data_in;
   logic        up_ready;
   logic        match;

   assign up_ready = !valid_ff || pos_ready;
   assign match    = (req_ch.status_byte == (STATUS_PITCH_BEND | {4'h0, midi_channel}));

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (up_ready) begin
         // other messages are dropped here and never occupy the pipe
         valid_in = req_ch.valid && match;
         data_in.pos = {req_ch.data_high, req_ch.data_low};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign req_ch.ready = up_ready;
   assign pos_valid    = valid_ff;
   assign pos_data     = data_ff;

endmodule

### rtl/core/fci_segment.sv
// ----------------------------------------------------------------------------
// fci_segment
// Segment lookup and slope multiply: finds the curve segment of the
// position and registers offset times slope with the segment base.
// ----------------------------------------------------------------------------
module fci_segment
   import fci_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         pos_valid,
   output logic         pos_ready,
   input  fci_pos_type  pos_data,
   output logic         prod_valid,
   input  logic         prod_ready,
   output fci_prod_type prod_data
);

   logic         valid_ff, valid_in;
   fci_prod_type data_ff, data_in;
   logic [SEG_W-1:0] seg;
   logic [D_W-1:0]   offset;

   assign pos_ready = !valid_ff || prod_ready;

   // breakpoints rise, so the segment is the count of inner points passed
   always_comb begin
      seg = '0;
      for (int i = 1; i < NUM_SEGS; i++) begin
         seg = seg + SEG_W'(pos_data.pos >= CURVE_X[i]);
      end
   end

   assign offset = D_W'(pos_data.pos - CURVE_X[seg]);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (pos_ready) begin
         valid_in        = pos_valid;
         data_in.product = PROD_W'(offset) * PROD_W'(SLOPE_TAB[seg]);
         data_in.base    = BASE_TAB[seg];
         data_in.top     = (pos_data.pos == TOP_POSITION);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign prod_valid = valid_ff;
   assign prod_data  = data_ff;

endmodule

### rtl/core/fci_blend.sv
// ----------------------------------------------------------------------------
// fci_blend
// Output stage: rounds off the guard bits, adds the segment base, clamps
// the top end and holds the level in the response register.
// ----------------------------------------------------------------------------
module fci_blend
   import fci_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         prod_valid,
   output logic         prod_ready,
   input  fci_prod_type prod_data,
   fci_rsp_if.source    rsp_ch
);

   logic               valid_ff, valid_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [PROD_W:0]    rounded;
   logic [LEVEL_W-1:0] ramp;

   assign prod_ready = !valid_ff || rsp_ch.ready;
   assign rounded    = {1'b0, prod_data.product} + ROUND_HALF;
   assign ramp       = rounded[GUARD_BITS +: LEVEL_W];

   always_comb begin
      valid_in = valid_ff;
      level_in = level_ff;
      if (prod_ready) begin
         valid_in = prod_valid;
         level_in = prod_data.top ? ONE_LEVEL : prod_data.base + ramp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      level_ff <= level_in;
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.fader_level = FADER_W'(level_ff);

endmodule

### rtl/core/fader_curve_interpolator.sv
// ----------------------------------------------------------------------------
// fader_curve_interpolator
// Maps pitch bend fader positions through an 11-point level curve.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ch carries one MIDI message per transfer (status, two data bytes).
//    Only pitch bends on the channel held in the control register make a
//    result; everything else is consumed and dropped.
//  - rsp_ch returns the level, unsigned with FRAC_BITS fraction bits, where
//    2^FRAC_BITS is full scale. One response per kept message, in order.
//  - csr_ch writes the 4-bit channel; it is always ready. Write it only while
//    no message is in flight.
//  - From request transfer to response valid, the message passes the input,
//    segment/multiply and response registers in that order.
//  - Throughput is one message per cycle while rsp_ch is ready; the three
//    stages each take a new item when empty or when their own item moves on.
//  - When rsp_ch stalls, the response holds and the stages behind it keep
//    filling; req_ch.ready drops only once all three stages hold items.
//  - Synchronous reset empties the pipeline and sets the channel to 0.
// ----------------------------------------------------------------------------
module fader_curve_interpolator
   import fci_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   fci_csr_if.sink   csr_ch,
   fci_req_if.sink   req_ch,
   fci_rsp_if.source rsp_ch
);

   logic [CHAN_W-1:0] midi_channel_ff, midi_channel_in;
   logic              pos_valid, pos_ready;
   fci_pos_type       pos_data;
   logic              prod_valid, prod_ready;
   fci_prod_type      prod_data;

   assign csr_ch.ready    = 1'b1;
   assign midi_channel_in = csr_ch.valid ? csr_ch.midi_channel : midi_channel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         midi_channel_ff <= '0;
      end else begin
         midi_channel_ff <= midi_channel_in;
      end
   end

   fci_filter u_filter (
      .clock        (clock),
      .reset        (reset),
      .midi_channel (midi_channel_ff),
      .req_ch       (req_ch),
      .pos_valid    (pos_valid),
      .pos_ready    (pos_ready),
      .pos_data     (pos_data)
   );

   fci_segment u_segment (
      .clock      (clock),
      .reset      (reset),
      .pos_valid  (pos_valid),
      .pos_ready  (pos_ready),
      .pos_data   (pos_data),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod_data  (prod_data)
   );

   fci_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod_data  (prod_data),
      .rsp_ch     (rsp_ch)
   );

endmodule

### rtl/core/fci_checker.sv
// ----------------------------------------------------------------------------
// fci_checker
// Port-level checks on the fader curve interpolator, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fci_checker
   import fci_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [FADER_W-1:0] fader_level,
   input logic               csr_valid,
   input logic               csr_ready
);

   logic req_xfer;
   logic quiet;

   assign req_xfer = req_valid && req_ready;
   assign quiet    = !req_xfer && rsp_ready;

   `FCI_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(fader_level), "stalled response changed")
   `FCI_ASSERT(a_level_max, clock, reset, rsp_valid |-> fader_level <= FADER_MAX, "level above full scale")
   `FCI_ASSERT(a_csr_ready, clock, reset, csr_valid |-> csr_ready, "register write refused")
   `FCI_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")
   `FCI_ASSERT(a_drain, clock, reset, quiet ##1 quiet ##1 quiet |=> !rsp_valid, "pipeline did not drain")

endmodule

bind fader_curve_interpolator fci_checker u_fci_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .fader_level (rsp_ch.fader_level),
   .csr_valid   (csr_ch.valid),
   .csr_ready   (csr_ch.ready)
);
